@@ hw/rtl/ilr_pkg.sv @@
// Shared constants, types and the numerator step table for the index linear regression unit.
package ilr_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;

  // Width of the shared adder and of the fit arithmetic (wraps modulo 2^64).
  localparam int WORD_BITS = 64;

  localparam int OUT_BITS    = 48;
  localparam int OUT_TDATA_W = ((2 * OUT_BITS + 2 + 7) / 8) * 8;

  // 2^(OUT_BITS-1), one bit wider than a result
  localparam logic [OUT_BITS:0] OUT_LIMIT = {2'b01, {(OUT_BITS - 1){1'b0}}};

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_SINGLE = 2'd1,
    STATUS_OVER   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_SXY = 2'd0,
    SRC_P   = 2'd1,
    SRC_SY  = 2'd2
  } num_src_t;

  typedef struct packed {
    num_src_t   src;
    logic [1:0] shift;
    logic       sub;
    logic       first;
  } num_op_t;

  localparam int NUM_STEPS = 10;

  // slope_num = 8Sxy + 4Sxy - 4P - 2P + 4Sy + 2Sy       (P = N*Sy)
  // icpt_num  = 4P - 2Sy - 4Sxy - 2Sxy
  function automatic num_op_t num_op(input logic [3:0] idx);
    num_op_t op;
    op = '{src: SRC_SXY, shift: 2'd0, sub: 1'b0, first: 1'b0};
    unique case (idx)
      4'd0:    op = '{src: SRC_SXY, shift: 2'd3, sub: 1'b0, first: 1'b1};
      4'd1:    op = '{src: SRC_SXY, shift: 2'd2, sub: 1'b0, first: 1'b0};
      4'd2:    op = '{src: SRC_P,   shift: 2'd2, sub: 1'b1, first: 1'b0};
      4'd3:    op = '{src: SRC_P,   shift: 2'd1, sub: 1'b1, first: 1'b0};
      4'd4:    op = '{src: SRC_SY,  shift: 2'd2, sub: 1'b0, first: 1'b0};
      4'd5:    op = '{src: SRC_SY,  shift: 2'd1, sub: 1'b0, first: 1'b0};
      4'd6:    op = '{src: SRC_P,   shift: 2'd2, sub: 1'b0, first: 1'b1};
      4'd7:    op = '{src: SRC_SY,  shift: 2'd1, sub: 1'b1, first: 1'b0};
      4'd8:    op = '{src: SRC_SXY, shift: 2'd2, sub: 1'b1, first: 1'b0};
      4'd9:    op = '{src: SRC_SXY, shift: 2'd1, sub: 1'b1, first: 1'b0};
      default: op = '{src: SRC_SXY, shift: 2'd0, sub: 1'b0, first: 1'b0};
    endcase
    return op;
  endfunction

endpackage

@@ hw/rtl/index_linear_regression_unit.sv @@
// Index linear regression: per-sample accumulation and a shared-adder fit sequencer.
// Samples are taken one per cycle while accumulating. After the last word of a run the unit
// is busy while the shared 64-bit adder runs four shift-add multiplies, the numerator sums
// and two restoring divisions, one step per cycle; a one-sample run skips the multiplies
// and the sums and runs one division.
// rst is synchronous, active high: clears the sums, the count and the output valid.
module index_linear_regression_unit #(
  parameter int MAX_SAMPLES = ilr_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = ilr_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ilr_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [ilr_pkg::OUT_TDATA_W-1:0]      m_tdata    // intercept, slope, status
);

  localparam int W        = ilr_pkg::WORD_BITS;
  localparam int OB       = ilr_pkg::OUT_BITS;
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int LOG_MAX  = $clog2(MAX_SAMPLES);
  localparam int SY_W     = SAMPLE_BITS + LOG_MAX + 1;
  localparam int SXY_W    = SAMPLE_BITS + 2 * LOG_MAX;
  localparam int Q_W      = 2 * CNT_W;
  localparam int DEN_W    = 3 * CNT_W;
  localparam int DIV_STEPS = W + FRAC_BITS;
  localparam int STEP_W   = $clog2(DIV_STEPS);

  localparam logic [1:0] MUL_P  = 2'd0;
  localparam logic [1:0] MUL_Q  = 2'd1;
  localparam logic [1:0] MUL_DS = 2'd2;
  localparam logic [1:0] MUL_DI = 2'd3;

  typedef enum logic [6:0] {
    ST_ACC   = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_NUM   = 7'b0000100,
    ST_DSIGN = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_DFIN  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic signed [SY_W-1:0]  sy;
  logic signed [SXY_W-1:0] sxy;
  logic [CNT_W-1:0]        count;
  logic                    overflowed;
  logic                    single;
  logic                    div_sel;   // 0 intercept, 1 slope
  logic [1:0]              mul_idx;
  logic [STEP_W-1:0]       step;
  logic [CNT_W-1:0]        mult_sr;
  logic [W-1:0]            acc;
  logic [W-1:0]            prod_p;
  logic [Q_W-1:0]          sq;
  logic [DEN_W-1:0]        den_s;
  logic [DEN_W-1:0]        den_i;
  logic [W-1:0]            num_s;
  logic [W-1:0]            num_i;
  logic [W-1:0]            mag;
  logic                    neg;
  logic [DEN_W-1:0]        rem;
  logic [OB:0]             quo;
  logic                    big;
  logic [OB-1:0]           icpt_res;
  logic [OB-1:0]           slope_res;

  // shared adder
  logic [W-1:0] add_a;
  logic [W-1:0] add_b;
  logic         add_sub;
  logic [W-1:0] add_sum;
  logic         add_carry;

  logic signed [SAMPLE_BITS-1:0] y;
  logic signed [SXY_W-1:0]       y_idx;
  logic [CNT_W-1:0]              count_new;
  logic                          room;
  logic                          in_acc;
  logic [W-1:0]                  sy64;
  logic [W-1:0]                  sxy64;
  logic [W-1:0]                  mcand;
  ilr_pkg::num_op_t              nop;
  logic [W-1:0]                  nopnd;
  logic [W-1:0]                  div_num;
  logic [DEN_W-1:0]              div_den;
  logic [DEN_W:0]                rem_sh;
  logic [OB+1:0]                 q_new;
  logic [OB:0]                   q_sat;
  logic [OB-1:0]                 fin_res;
  ilr_pkg::status_t              status;

  assign s_tready  = (state == ST_ACC);
  assign in_acc    = s_tvalid && s_tready;
  assign y         = s_tdata[SAMPLE_BITS-1:0];
  assign y_idx     = SXY_W'($signed({1'b0, count}) * y);
  assign room      = (count < CNT_W'(MAX_SAMPLES));
  assign count_new = room ? count + CNT_W'(1) : count;
  assign sy64      = W'(sy);
  assign sxy64     = W'(sxy);
  assign nop       = ilr_pkg::num_op(step[3:0]);
  assign rem_sh    = {rem, mag[W-1]};
  assign q_new     = add_carry ? {quo, 1'b1} : {quo, 1'b0};
  assign fin_res   = add_sum[OB-1:0];

  always_comb begin
    case (mul_idx)
      MUL_P:   mcand = sy64;
      MUL_Q:   mcand = W'(count);
      MUL_DS:  mcand = W'(sq - Q_W'(1));
      default: mcand = W'(count) + W'(1);
    endcase
  end

  always_comb begin
    case (nop.src)
      ilr_pkg::SRC_SXY: nopnd = sxy64;
      ilr_pkg::SRC_P:   nopnd = prod_p;
      default:          nopnd = sy64;
    endcase
  end

  always_comb begin
    if (single) begin
      div_num = sy64;
      div_den = DEN_W'(1);
    end else if (div_sel) begin
      div_num = num_s;
      div_den = den_s;
    end else begin
      div_num = num_i;
      div_den = den_i;
    end
  end

  always_comb begin
    if (neg) begin
      q_sat = (big || quo > ilr_pkg::OUT_LIMIT) ? ilr_pkg::OUT_LIMIT : quo;
    end else begin
      q_sat = (big || quo > ilr_pkg::OUT_LIMIT - 1'b1) ? ilr_pkg::OUT_LIMIT - 1'b1 : quo;
    end
  end

  always_comb begin
    if (overflowed) status = ilr_pkg::STATUS_OVER;
    else if (single) status = ilr_pkg::STATUS_SINGLE;
    else status = ilr_pkg::STATUS_OK;
  end

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state)
      ST_MUL: begin
        add_a = {acc[W-2:0], 1'b0};
        add_b = mult_sr[CNT_W-1] ? mcand : '0;
      end
      ST_NUM: begin
        add_a   = nop.first ? '0 : acc;
        add_b   = nopnd << nop.shift;
        add_sub = nop.sub;
      end
      ST_DSIGN: begin
        add_b   = div_num;
        add_sub = div_num[W-1];
      end
      ST_DIV: begin
        add_a   = W'(rem_sh);
        add_b   = W'(div_den);
        add_sub = 1'b1;
      end
      ST_DFIN: begin
        add_b   = W'(q_sat);
        add_sub = neg;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  assign {add_carry, add_sum} = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b}
                                + (W + 1)'(add_sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_ACC;
      sy         <= '0;
      sxy        <= '0;
      count      <= '0;
      overflowed <= 1'b0;
      m_tvalid   <= 1'b0;
      single     <= 1'b0;
      div_sel    <= 1'b0;
      mul_idx    <= '0;
      step       <= '0;
    end else begin
      // in ST_DONE the valid is handled by the state itself
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      unique case (state)
        ST_ACC: begin
          if (in_acc) begin
            if (room) begin
              sy    <= sy + SY_W'(y);
              sxy   <= sxy + y_idx;
              count <= count_new;
            end else begin
              overflowed <= 1'b1;
            end
            if (s_tlast) begin
              single  <= (count == '0);
              div_sel <= 1'b0;
              mul_idx <= MUL_P;
              step    <= '0;
              acc     <= '0;
              mult_sr <= count_new;
              state   <= (count == '0) ? ST_DSIGN : ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (step == STEP_W'(CNT_W - 1)) begin
            case (mul_idx)
              MUL_P:   prod_p <= add_sum;
              MUL_Q:   sq     <= add_sum[Q_W-1:0];
              MUL_DS:  den_s  <= add_sum[DEN_W-1:0];
              default: den_i  <= add_sum[DEN_W-1:0];
            endcase
            acc     <= '0;
            mult_sr <= count;
            step    <= '0;
            mul_idx <= mul_idx + 2'd1;
            if (mul_idx == MUL_DI) state <= ST_NUM;
          end else begin
            mult_sr <= mult_sr << 1;
            acc     <= add_sum;
            step    <= step + STEP_W'(1);
          end
        end
        ST_NUM: begin
          acc  <= add_sum;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(5)) num_s <= add_sum;
          if (step == STEP_W'(ilr_pkg::NUM_STEPS - 1)) begin
            num_i <= add_sum;
            state <= ST_DSIGN;
          end
        end
        ST_DSIGN: begin
          neg   <= div_num[W-1];
          mag   <= add_sum;
          rem   <= '0;
          quo   <= '0;
          big   <= 1'b0;
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= add_carry ? add_sum[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          mag  <= mag << 1;
          step <= step + STEP_W'(1);
          // once past the limit the quotient stays pinned just above it
          if (q_new > (OB + 2)'(ilr_pkg::OUT_LIMIT)) begin
            big <= 1'b1;
            quo <= ilr_pkg::OUT_LIMIT + 1'b1;
          end else begin
            quo <= q_new[OB:0];
          end
          if (step == STEP_W'(DIV_STEPS - 1)) state <= ST_DFIN;
        end
        ST_DFIN: begin
          if (!div_sel) begin
            icpt_res <= fin_res;
            if (single) begin
              slope_res <= '0;
              state     <= ST_DONE;
            end else begin
              div_sel <= 1'b1;
              state   <= ST_DSIGN;
            end
          end else begin
            slope_res <= fin_res;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= ilr_pkg::OUT_TDATA_W'({status, slope_res, icpt_res});
            sy         <= '0;
            sxy        <= '0;
            count      <= '0;
            overflowed <= 1'b0;
            state      <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

endmodule

@@ sim/tb_top.sv @@
// Testbench for the index linear regression unit: directed and random runs, checked per result.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_N       = ilr_pkg::MAX_SAMPLES_DEF;
  localparam int FRAC        = ilr_pkg::FRAC_BITS_DEF;
  localparam int OBITS       = ilr_pkg::OUT_BITS;
  localparam int IN_W        = ((ilr_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int SETTLE_CYC  = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 900;
  localparam longint unsigned QLIM = 64'd1 << (OBITS - 1);

  typedef struct {
    logic signed [OBITS-1:0] intercept;
    logic signed [OBITS-1:0] slope;
    ilr_pkg::status_t        status;
  } fit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ilr_pkg::OUT_TDATA_W-1:0] m_tdata;

  index_linear_regression_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // fit predictor state
  longint unsigned run_sy  = 0;
  longint unsigned run_sxy = 0;
  longint unsigned run_n   = 0;
  bit              run_over = 1'b0;
  fit_t            fit_queue[$];

  int  err_count  = 0;
  int  words_sent = 0;
  bit  tx_idle    = 1'b1;
  bit  rx_idle    = 1'b1;
  int  hold_len   = 0;

  // trunc(num * 2^FRAC / den), num two's complement, den > 0, saturated to 48 bits
  function automatic logic [OBITS-1:0] fixed_quotient(longint unsigned num,
                                                      longint unsigned den);
    bit              neg;
    bit              big;
    longint unsigned mag;
    longint unsigned rem;
    longint unsigned quo;
    longint unsigned b;
    neg = num[63];
    mag = neg ? (64'd0 - num) : num;
    rem = 0;
    quo = 0;
    big = 1'b0;
    for (int k = 63 + FRAC; k >= 0; k--) begin
      b = (k >= FRAC) ? ((mag >> (k - FRAC)) & 64'd1) : 64'd0;
      rem = (rem << 1) | b;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'd1;
      end
      if (quo > QLIM) begin
        big = 1'b1;
        quo = QLIM + 1;
      end
    end
    if (neg) begin
      if (big || quo > QLIM) quo = QLIM;
      quo = 64'd0 - quo;
    end else if (big || quo > QLIM - 1) begin
      quo = QLIM - 1;
    end
    return quo[OBITS-1:0];
  endfunction

  function automatic void predict_word(logic signed [IN_W-1:0] smp, logic lst);
    longint unsigned y;
    longint unsigned n;
    fit_t            fit;
    y = longint'(smp);
    if (run_n < MAX_N) begin
      run_sy  += y;
      run_sxy += run_n * y;
      run_n++;
    end else begin
      run_over = 1'b1;
    end
    if (!lst) return;
    n = run_n;
    if (n <= 1) begin
      fit.intercept = fixed_quotient(run_sy, 64'd1);
      fit.slope     = '0;
      fit.status    = run_over ? ilr_pkg::STATUS_OVER : ilr_pkg::STATUS_SINGLE;
    end else begin
      fit.intercept = fixed_quotient(2 * (2 * n - 1) * run_sy - 6 * run_sxy, n * (n + 1));
      fit.slope     = fixed_quotient(12 * run_sxy - 6 * (n - 1) * run_sy, n * (n * n - 1));
      fit.status    = run_over ? ilr_pkg::STATUS_OVER : ilr_pkg::STATUS_OK;
    end
    fit_queue.push_back(fit);
    run_sy   = 0;
    run_sxy  = 0;
    run_n    = 0;
    run_over = 1'b0;
  endfunction

  task automatic send_word(input logic signed [IN_W-1:0] smp, input logic lst);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    predict_word(smp, lst);
    words_sent++;
  endtask

  function automatic logic signed [IN_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2, 3:    return IN_W'($signed($urandom_range(0, 64)) - 32);
      default: return IN_W'($urandom());
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_word(draw_sample(), i == len - 1);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_single_samples();
    send_word(24'sh7FFFFF, 1'b1);
    send_word(24'sh800000, 1'b1);
    send_word(24'sh000000, 1'b1);
  endtask

  task automatic test_short_runs();
    send_word(24'sh7FFFFF, 1'b0);
    send_word(24'sh800000, 1'b1);
    send_word(24'sh800000, 1'b0);
    send_word(24'sh7FFFFF, 1'b1);
    for (int i = 0; i < 3; i++) send_word(24'sh7FFFFF, i == 2);
    send_word(-24'sd1, 1'b0);
    send_word(24'sd0, 1'b0);
    send_word(24'sd1, 1'b1);
    send_word(24'sh555555, 1'b0);
    send_word(24'shAAAAAA, 1'b1);
    for (int i = 0; i < 5; i++) send_word(IN_W'(i * 24'sd1000003 - 24'sd2000000), i == 4);
  endtask

  // output held off long enough that results back up into the input
  task automatic test_backpressure();
    tx_idle  = 1'b0;
    hold_len = 1500;
    for (int r = 0; r < 6; r++) send_run($urandom_range(1, 4));
    tx_idle = 1'b1;
  endtask

  task automatic test_random_runs();
    int start;
    int len;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
      send_run(len);
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      gap = rx_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid && hold_len == 0);
    end
  end

  function automatic void check_field(string name, logic [OBITS-1:0] exp_v,
                                      logic [OBITS-1:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      if (err_count <= 10)
        $display("mismatch %s: expected %0d actual %0d", name,
                 $signed(exp_v), $signed(act_v));
    end
  endfunction

  always @(posedge clk) begin
    fit_t fit;
    if (!rst && m_tvalid && m_tready) begin
      if (fit_queue.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result word: %h", m_tdata);
      end else begin
        fit = fit_queue.pop_front();
        check_field("intercept", fit.intercept, m_tdata[OBITS-1:0]);
        check_field("slope", fit.slope, m_tdata[2*OBITS-1:OBITS]);
        check_field("status", OBITS'(fit.status), OBITS'(m_tdata[2*OBITS+1:2*OBITS]));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_samples();
    test_short_runs();
    test_backpressure();
    test_random_runs();
    s_tvalid <= 1'b0;
    while (fit_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (fit_queue.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived", fit_queue.size());
    end
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ilr_pkg.sv
hw/rtl/index_linear_regression_unit.sv
sim/tb_top.sv
